// File: src/stb_pkg.sv
package stb_pkg;

   // Field widths fixed by the channel formats
   localparam int unsigned OFFSET_WIDTH = 48;
   localparam int unsigned TIME_WIDTH   = 32;

   // Default fraction width of the timestamp and offset
   localparam int unsigned FRACTION_BITS_DEFAULT = 16;

   // Tick rate after reset
   localparam logic [TIME_WIDTH-1:0] TPS_RESET = 32'd50000000;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_READ,
      OP_SYNC,
      OP_UNSYNC
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_ROLLOVER,
      KIND_READING,
      KIND_SYNC_APPLIED,
      KIND_SYNC_REJECTED
   } kind_type;

   // Datapath operations issued by the controller
   typedef enum logic [2:0] {
      DP_NONE,
      DP_LOAD,
      DP_TICK,
      DP_DIV_STEP,
      DP_MUL,
      DP_ADD,
      DP_FIX,
      DP_UNSYNC
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
      kind_type  kind;
   } dp_cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       synced;
      logic       rollover;
      logic       div_last;
   } dp_status_type;

endpackage

// File: src/stb_ifs.sv
interface stb_req_if import stb_pkg::*; ();
   logic                           valid;
   logic                           ready;
   opcode_type                     opcode;
   logic signed [OFFSET_WIDTH-1:0] offset_q16;

   modport source (output valid, opcode, offset_q16, input ready);
   modport sink   (input valid, opcode, offset_q16, output ready);
endinterface

interface stb_rsp_if import stb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   kind_type              result_kind;
   logic [TIME_WIDTH-1:0] seconds_value;
   logic [TIME_WIDTH-1:0] timestamp_q16;

   modport source (output valid, result_kind, seconds_value, timestamp_q16, input ready);
   modport sink   (input valid, result_kind, seconds_value, timestamp_q16, output ready);
endinterface

interface stb_csr_if import stb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TIME_WIDTH-1:0] ticks_per_second;

   modport source (output valid, ticks_per_second, input ready);
   modport sink   (input valid, ticks_per_second, output ready);
endinterface

// File: src/stb_datapath.sv
module stb_datapath import stb_pkg::*; #(
   parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  opcode_type                     req_opcode,
   input  logic signed [OFFSET_WIDTH-1:0] req_offset_q16,
   input  logic                           csr_valid,
   input  logic [TIME_WIDTH-1:0]          csr_data,
   input  dp_cmd_type                     cmd,
   output dp_status_type                  status,
   output kind_type                       rsp_kind,
   output logic [TIME_WIDTH-1:0]          rsp_seconds,
   output logic [TIME_WIDTH-1:0]          rsp_timestamp
);

   localparam int unsigned CNT_W  = $clog2(FRACTION_BITS);
   localparam int unsigned PROD_W = FRACTION_BITS + TIME_WIDTH;
   localparam int unsigned WIDE_W = TIME_WIDTH + 2;

   // Architectural state
   logic [TIME_WIDTH-1:0] tps_ff;
   logic [TIME_WIDTH-1:0] tick_ff, tick_in;
   logic [TIME_WIDTH-1:0] sec_ff, sec_in;
   logic                  synced_ff, synced_in;

   // Per-item working registers
   opcode_type               opcode_ff;
   logic                     neg_ff;
   logic [TIME_WIDTH-1:0]    ipart_ff;
   logic [FRACTION_BITS-1:0] fpart_ff;
   logic                     sat_ff;
   logic [TIME_WIDTH-1:0]    rem_ff, rem_in;
   logic [FRACTION_BITS-1:0] quo_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [WIDE_W-1:0]        n_ff;
   logic [TIME_WIDTH-1:0]    ioff_ff;

   // Result register
   kind_type              rsp_kind_ff;
   logic [TIME_WIDTH-1:0] rsp_sec_ff;
   logic [TIME_WIDTH-1:0] rsp_ts_ff;

   logic [OFFSET_WIDTH-1:0]             raw;
   logic [OFFSET_WIDTH-1:0]             mag;
   logic [TIME_WIDTH:0]                 tick_next;
   logic                                rollover;
   logic [TIME_WIDTH:0]                 rem_sh;
   logic [TIME_WIDTH:0]                 rem_sub;
   logic                                div_ge;
   logic [TIME_WIDTH-1:0]               delta;
   logic [WIDE_W-1:0]                   tps_wide;
   logic [WIDE_W-1:0]                   n_sum;
   logic                                carry_up;
   logic                                carry_down;
   logic [TIME_WIDTH-1:0]               sec_corr;
   logic [TIME_WIDTH+FRACTION_BITS-1:0] sec_sh;
   logic [FRACTION_BITS-1:0]            frac;
   logic [TIME_WIDTH-1:0]               ts;

   // Split the offset magnitude into whole seconds and fraction
   assign raw = req_offset_q16;
   assign mag = raw[OFFSET_WIDTH-1] ? OFFSET_WIDTH'(~raw + 48'd1) : raw;

   // Tick rollover check
   assign tick_next = {1'b0, tick_ff} + 33'd1;
   assign rollover  = tick_next >= {1'b0, tps_ff};

   // One restoring division step for the fraction
   assign rem_sh  = {rem_ff, 1'b0};
   assign div_ge  = rem_sh >= {1'b0, tps_ff};
   assign rem_sub = rem_sh - {1'b0, tps_ff};
   assign rem_in  = div_ge ? rem_sub[TIME_WIDTH-1:0] : rem_sh[TIME_WIDTH-1:0];

   // Sync offset in ticks and the adjusted count
   assign delta    = prod_ff[PROD_W-1:FRACTION_BITS];
   assign tps_wide = {2'b00, tps_ff};
   assign n_sum    = neg_ff ? ({2'b00, tick_ff} - {2'b00, delta})
                            : ({2'b00, tick_ff} + {2'b00, delta});

   // Single carry or borrow correction into seconds
   assign carry_down = n_ff[WIDE_W-1];
   assign carry_up   = !carry_down && (n_ff >= tps_wide);
   assign sec_corr   = carry_up ? 32'd1 : (carry_down ? '1 : '0);

   always_comb begin
      tick_in   = tick_ff;
      sec_in    = sec_ff;
      synced_in = synced_ff;
      case (cmd.op)
         DP_TICK: begin
            if (rollover) begin
               tick_in = '0;
               sec_in  = sec_ff + 32'd1;
            end else begin
               tick_in = tick_next[TIME_WIDTH-1:0];
            end
         end
         DP_FIX: begin
            if (carry_up) begin
               tick_in = TIME_WIDTH'(n_ff - tps_wide);
            end else if (carry_down) begin
               tick_in = TIME_WIDTH'(n_ff + tps_wide);
            end else begin
               tick_in = n_ff[TIME_WIDTH-1:0];
            end
            sec_in    = sec_ff + ioff_ff + sec_corr;
            synced_in = 1'b1;
         end
         DP_UNSYNC: synced_in = 1'b0;
         default: ;
      endcase
   end

   // Hold the time base and the tick rate
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff    <= TPS_RESET;
         tick_ff   <= '0;
         sec_ff    <= '0;
         synced_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            tps_ff <= csr_data;
         end
         tick_ff   <= tick_in;
         sec_ff    <= sec_in;
         synced_ff <= synced_in;
      end
   end

   // Capture the item and advance the working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_LOAD: begin
            opcode_ff <= req_opcode;
            neg_ff    <= raw[OFFSET_WIDTH-1];
            ipart_ff  <= TIME_WIDTH'(mag >> FRACTION_BITS);
            fpart_ff  <= mag[FRACTION_BITS-1:0];
            sat_ff    <= tick_ff >= tps_ff;
            rem_ff    <= tick_ff;
            quo_ff    <= '0;
            cnt_ff    <= '0;
         end
         DP_DIV_STEP: begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[FRACTION_BITS-2:0], div_ge};
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         DP_MUL: prod_ff <= PROD_W'(fpart_ff) * PROD_W'(tps_ff);
         DP_ADD: begin
            n_ff    <= n_sum;
            ioff_ff <= neg_ff ? TIME_WIDTH'(-ipart_ff) : ipart_ff;
         end
         default: ;
      endcase
   end

   // Form the timestamp of a reading
   assign sec_sh = {sec_ff, {FRACTION_BITS{1'b0}}};
   assign frac   = sat_ff ? '1 : quo_ff;
   assign ts     = sec_sh[TIME_WIDTH-1:0] + TIME_WIDTH'(frac);

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_kind_ff <= cmd.kind;
         rsp_sec_ff  <= sec_ff;
         rsp_ts_ff   <= (cmd.kind == KIND_READING) ? ts : '0;
      end
   end

   assign status.opcode   = opcode_ff;
   assign status.synced   = synced_ff;
   assign status.rollover = rollover;
   assign status.div_last = cnt_ff == CNT_W'(FRACTION_BITS - 1);

   assign rsp_kind      = rsp_kind_ff;
   assign rsp_seconds   = rsp_sec_ff;
   assign rsp_timestamp = rsp_ts_ff;

endmodule

// File: src/stb_ctrl.sv
module stb_ctrl import stb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DIV,
      ST_ADD,
      ST_FIX,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = DP_NONE;
      cmd.rsp_load = 1'b0;
      cmd.kind     = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.opcode)
               OP_TICK: begin
                  cmd.op = DP_TICK;
                  if (status.rollover) begin
                     kind_in  = KIND_ROLLOVER;
                     state_in = ST_EMIT;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               OP_READ: state_in = ST_DIV;
               OP_SYNC: begin
                  if (status.synced) begin
                     kind_in  = KIND_SYNC_REJECTED;
                     state_in = ST_EMIT;
                  end else begin
                     cmd.op   = DP_MUL;
                     state_in = ST_ADD;
                  end
               end
               OP_UNSYNC: begin
                  cmd.op   = DP_UNSYNC;
                  state_in = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DIV: begin
            cmd.op = DP_DIV_STEP;
            if (status.div_last) begin
               kind_in  = KIND_READING;
               state_in = ST_EMIT;
            end
         end
         ST_ADD: begin
            cmd.op   = DP_ADD;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.op   = DP_FIX;
            kind_in  = KIND_SYNC_APPLIED;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Wait until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state, result kind and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= KIND_ROLLOVER;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/synced_time_base.sv
// Time base with a sub-second tick count and a seconds count. One item is
// taken at a time; req ready is high only between items. A tick reports
// only when it rolls over, an unsync never reports, and the read fraction
// comes out of a restoring divider that produces one quotient bit per cycle,
// and that loop sets the longest item spacing. A sync runs the fraction
// times the tick rate through the multiplier, then an add and a carry
// correction step. Results sit in an output register, so the next item is
// taken while a result still waits; a finished item stalls only while the
// previous result is not yet taken. The tick rate may be written only while
// the block is idle, and the write channel is always ready.
module synced_time_base import stb_pkg::*; #(
   parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   stb_req_if.sink   req_bus,
   stb_rsp_if.source rsp_bus,
   stb_csr_if.sink   csr_bus
);

   dp_cmd_type    cmd;
   dp_status_type status;

   stb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   stb_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_opcode     (req_bus.opcode),
      .req_offset_q16 (req_bus.offset_q16),
      .csr_valid      (csr_bus.valid),
      .csr_data       (csr_bus.ticks_per_second),
      .cmd            (cmd),
      .status         (status),
      .rsp_kind       (rsp_bus.result_kind),
      .rsp_seconds    (rsp_bus.seconds_value),
      .rsp_timestamp  (rsp_bus.timestamp_q16)
   );

   // Accept every register write
   assign csr_bus.ready = 1'b1;

endmodule

// File: src/stb_checker.sv
module stb_checker import stb_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input kind_type              rsp_kind,
   input logic [TIME_WIDTH-1:0] rsp_timestamp
);

   // One item in flight: no transfer right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
   else $error("request taken while an item is in flight");

   // Only readings carry a timestamp
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_READING) |-> rsp_timestamp == '0)
   else $error("timestamp set on a result that is not a reading");

   // Result stays offered until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
   else $error("result dropped before transfer");

   // No result right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
   else $error("result offered right after reset");

endmodule

bind synced_time_base stb_checker u_stb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_kind      (rsp_bus.result_kind),
   .rsp_timestamp (rsp_bus.timestamp_q16)
);
